FILE: rtl/core/low_power_probing_duty_cycler_top_defines.svh
// assertion macros for the low-power probing duty cycler
// used by the checker module only
`ifndef LOW_POWER_PROBING_DUTY_CYCLER_TOP_DEFINES_SVH
`define LOW_POWER_PROBING_DUTY_CYCLER_TOP_DEFINES_SVH
// a condition at one edge implies a consequence at the next
`define LPP_ASSERT_NEXT(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error(msg);
// a condition implies a consequence at the same edge
`define LPP_ASSERT_NOW(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error(msg);
`endif

FILE: rtl/core/lppdc_pkg.sv
// shared types and constants for the low-power probing duty cycler
// no dependencies
`timescale 1ns / 1ps
package lppdc_pkg;
    localparam int QUEUE_SLOTS  = 4;
    localparam int SLOT_BITS    = 2;
    localparam int ADDRESS_BITS = 16;
    localparam int TIMER_BITS   = 16;
    localparam int LIFE_BITS    = 17;
    localparam int MAX_RESULTS  = 5;
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [2:0] {
        MODE_TICK    = 3'd0,
        MODE_ENQUEUE = 3'd1,
        MODE_PROBE   = 3'd2,
        MODE_DATA    = 3'd3,
        MODE_REPORT  = 3'd4,
        MODE_LISTEN  = 3'd5,
        MODE_POWER   = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        KIND_ACCEPTED = 3'd0,
        KIND_PROBE    = 3'd1,
        KIND_TRANSMIT = 3'd2,
        KIND_COMPLETE = 3'd3,
        KIND_DELIVER  = 3'd4
    } kind_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_ACK  = 2'd1;
    localparam logic [1:0] ST_NO_SLOT = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LISTEN = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFF    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NODE   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,     // waiting for a word
        S_SCAN,     // one slot per cycle (expiry, probe, free search)
        S_DECIDE,   // mode-specific step after the scan
        S_MOD,      // shared subtractor: restoring modulo, one bit a cycle
        S_CYCLE,    // finish the duty cycle step
        S_EMIT,     // present result word
        S_DONE      // never entered; S_EMIT ends an item with no result left
    } state_t;

    // one result word
    typedef struct packed {
        logic                    last;
        logic                    radio_on;
        logic [ADDRESS_BITS-1:0] peer;
        logic                    tx;
        logic [1:0]              status;
        logic [SLOT_BITS-1:0]    slot;
        logic [2:0]              kind;
    } result_t;
endpackage

FILE: rtl/core/low_power_probing_duty_cycler_top.sv
// Sequence: an item keeps s_tready low through the slot scan (S_SCAN), the decide step
// (S_DECIDE), the shared bit-serial modulo (S_MOD) on a busy probe tick and the duty cycle
// step (S_CYCLE) when the phase timer fires, then presents its result words in S_EMIT.
// Handshake: one item at a time; s_tready is low from acceptance until the last result word
// has been taken. Results queue in a 5-entry buffer.
// Reset: aresetn synchronous active low; registers to reset values, slots empty. Uses lppdc_pkg.
`timescale 1ns / 1ps
module low_power_probing_duty_cycler_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mode[2:0] address[18:3] source_address[34:19] slot[36:35] flag[37]
    // power_on[38] listen_periods[46:39] channel_busy[47] receiving[48]
    // random_value[64:49], zero fill to 72
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // kind[2:0] result_slot[4:3] status[6:5] transmissions[7] peer_address[23:8]
    // radio_on[24], zero fill to 32
    output logic [31:0] m_tdata,
    output logic        m_tlast
);
    import lppdc_pkg::*;

    // configuration
    logic [15:0] listen_reg, off_reg, node_reg;
    // state
    logic        phase_reg;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [15:0] adj_reg, adj_next;
    logic [7:0]  lleft_reg, lleft_next;
    logic        duty_reg, duty_next, radio_reg, radio_next, phase_next;
    logic [QUEUE_SLOTS-1:0] valid_reg, valid_next, sent_reg, sent_next;
    logic [ADDRESS_BITS-1:0] dest_reg [QUEUE_SLOTS];
    logic [LIFE_BITS-1:0]    life_reg [QUEUE_SLOTS];
    // item
    logic [71:0] in_reg;
    state_t      st_reg, st_next;
    logic [SLOT_BITS:0] idx_reg, idx_next;
    // modulo unit
    logic [15:0] rem_reg, rem_next, quo_src_reg, quo_src_next;
    logic [4:0]  bit_reg, bit_next;
    // result buffer
    result_t     res_reg [MAX_RESULTS];
    logic [2:0]  cnt_reg, cnt_next, rd_reg, rd_next;
    logic        res_we;
    result_t     res_w;

    logic [2:0]  mode;
    logic [15:0] addr, src, rnd;
    logic [SLOT_BITS-1:0] rslot, cur;
    logic [15:0] div;
    logic [16:0] sub;
    logic [16:0] life_sum;
    logic [17:0] life_uni;
    logic [16:0] cur_off;
    logic [16:0] floor2;
    logic [QUEUE_SLOTS-1:0] vclr;
    logic        life_we;
    logic [LIFE_BITS-1:0] life_w;
    logic        dest_we;
    logic [SLOT_BITS-1:0] wslot;
    logic        found_reg, found_next;
    logic [SLOT_BITS-1:0] free_reg, free_next;

    assign mode  = in_reg[2:0];
    assign addr  = in_reg[18:3];
    assign src   = in_reg[34:19];
    assign rslot = in_reg[36:35];
    assign rnd   = in_reg[64:49];
    assign cur   = idx_reg[SLOT_BITS-1:0];
    assign div   = {1'b0, off_reg[15:1]};
    assign sub   = {rem_reg, quo_src_reg[15]} - {1'b0, div};

    assign s_tready = (st_reg == S_IDLE);
    assign m_tvalid = (st_reg == S_EMIT) && (cnt_reg != '0);
    assign m_tlast  = res_reg[rd_reg].last;
    assign m_tdata  = {7'd0, res_reg[rd_reg].radio_on, res_reg[rd_reg].peer,
                       res_reg[rd_reg].tx, res_reg[rd_reg].status,
                       res_reg[rd_reg].slot, res_reg[rd_reg].kind};

    // sequencer and state update
    always_comb begin
        st_next = st_reg; idx_next = idx_reg; timer_next = timer_reg;
        adj_next = adj_reg; lleft_next = lleft_reg; duty_next = duty_reg;
        radio_next = radio_reg; phase_next = phase_reg; valid_next = valid_reg;
        sent_next = sent_reg; rem_next = rem_reg; quo_src_next = quo_src_reg;
        bit_next = bit_reg; cnt_next = cnt_reg; rd_next = rd_reg;
        found_next = found_reg; free_next = free_reg;
        res_we = 1'b0; res_w = '0; life_we = 1'b0; life_w = '0;
        dest_we = 1'b0; wslot = cur; vclr = '0;
        life_sum = {1'b0, listen_reg} + {1'b0, off_reg};
        life_uni = {1'b0, life_sum} + {2'b0, life_sum[16:1]};
        cur_off  = {1'b0, off_reg} - {1'b0, adj_reg};
        floor2   = {listen_reg, 1'b0};
        case (st_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    st_next = S_SCAN; idx_next = '0; cnt_next = '0; rd_next = '0;
                    found_next = 1'b0;
                end
            end
            S_SCAN: begin
                if (idx_reg == (SLOT_BITS+1)'(QUEUE_SLOTS)) begin
                    st_next = S_DECIDE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    case (mode)
                        MODE_TICK: if (valid_reg[cur]) begin
                            if (life_reg[cur] > 17'd1) begin
                                life_we = 1'b1; life_w = life_reg[cur] - 1'b1;
                            end else if (cnt_reg < 3'(MAX_RESULTS - 1)) begin
                                vclr[cur] = 1'b1;
                                valid_next = valid_reg & ~vclr;
                                if (valid_next == '0 && lleft_reg == 8'd0 && duty_reg)
                                    radio_next = 1'b0;
                                res_we = 1'b1;
                                res_w.kind = KIND_COMPLETE; res_w.slot = cur;
                                res_w.status = ST_NO_ACK; res_w.tx = sent_reg[cur];
                                res_w.radio_on = radio_next;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        MODE_ENQUEUE: if (!valid_reg[cur] && !found_reg) begin
                            found_next = 1'b1; free_next = cur;
                        end
                        MODE_PROBE: if (valid_reg[cur] && cnt_reg < 3'(MAX_RESULTS)
                                        && (dest_reg[cur] == addr || dest_reg[cur] == '0)
                                        && !(dest_reg[cur] != '0 && sent_reg[cur])) begin
                            sent_next[cur] = 1'b1;
                            res_we = 1'b1;
                            res_w.kind = KIND_TRANSMIT; res_w.slot = cur;
                            res_w.radio_on = radio_reg;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_DECIDE: begin
                st_next = S_EMIT;
                case (mode)
                    MODE_TICK: begin
                        if (timer_reg > TIMER_BITS'(1)) begin
                            timer_next = timer_reg - 1'b1;
                        end else if (!phase_reg) begin
                            radio_next = 1'b1;
                            if (in_reg[47]) begin
                                rem_next = '0; quo_src_next = rnd; bit_next = '0;
                                st_next = (div == '0) ? S_CYCLE : S_MOD;
                                if (div == '0) adj_next = '0;
                            end else begin
                                res_we = 1'b1; res_w.kind = KIND_PROBE;
                                res_w.radio_on = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                                st_next = S_CYCLE;
                            end
                        end else begin
                            st_next = S_CYCLE;
                        end
                    end
                    MODE_ENQUEUE: begin
                        res_we = 1'b1; cnt_next = cnt_reg + 1'b1;
                        if (!found_reg) begin
                            res_w.kind = KIND_COMPLETE; res_w.status = ST_NO_SLOT;
                            res_w.radio_on = radio_reg;
                        end else begin
                            wslot = free_reg;
                            valid_next[free_reg] = 1'b1; sent_next[free_reg] = 1'b0;
                            dest_we = 1'b1; life_we = 1'b1;
                            if (addr == '0) life_w = life_sum;
                            else life_w = (life_uni > 18'h1FFFF) ? 17'h1FFFF
                                                                : life_uni[16:0];
                            radio_next = 1'b1;
                            res_w.kind = KIND_ACCEPTED; res_w.slot = free_reg;
                            res_w.radio_on = 1'b1;
                        end
                    end
                    MODE_DATA: begin
                        if (duty_reg) radio_next = 1'b0;
                        if (addr == '0 || addr == node_reg) begin
                            res_we = 1'b1; cnt_next = cnt_reg + 1'b1;
                            res_w.kind = KIND_DELIVER; res_w.peer = src;
                            res_w.radio_on = duty_reg ? 1'b0 : radio_reg;
                        end
                    end
                    MODE_REPORT: if (valid_reg[rslot]) begin
                        vclr[rslot] = 1'b1;
                        valid_next = valid_reg & ~vclr;
                        if (valid_next == '0 && lleft_reg == 8'd0 && duty_reg)
                            radio_next = 1'b0;
                        res_we = 1'b1; cnt_next = cnt_reg + 1'b1;
                        res_w.kind = KIND_COMPLETE; res_w.slot = rslot;
                        res_w.status = (sent_reg[rslot] && in_reg[37]) ? ST_OK : ST_NO_ACK;
                        res_w.tx = sent_reg[rslot]; res_w.radio_on = radio_next;
                    end
                    MODE_LISTEN: begin
                        lleft_next = in_reg[46:39]; radio_next = 1'b1;
                    end
                    MODE_POWER: begin
                        duty_next = in_reg[38];
                        radio_next = in_reg[38] | in_reg[37];
                    end
                    default: ;
                endcase
            end
            S_MOD: begin
                // restoring modulo step on the shared subtractor
                quo_src_next = {quo_src_reg[14:0], 1'b0};
                rem_next = sub[16] ? {rem_reg[14:0], quo_src_reg[15]} : sub[15:0];
                bit_next = bit_reg + 1'b1;
                if (bit_reg == 5'd15) begin
                    adj_next = rem_next; st_next = S_CYCLE;
                end
            end
            S_CYCLE: begin
                st_next = S_EMIT;
                if (!phase_reg) begin
                    phase_next = 1'b1; timer_next = listen_reg;
                end else begin
                    phase_next = 1'b0;
                    if (valid_reg == '0 && lleft_reg == 8'd0) begin
                        if (!in_reg[48] && duty_reg) radio_next = 1'b0;
                        adj_next = '0;
                        if (cur_off[16] || cur_off < floor2)
                            timer_next = floor2[16] ? '1 : floor2[15:0];
                        else
                            timer_next = cur_off[15:0];
                    end else begin
                        if (valid_reg == '0) lleft_next = lleft_reg - 1'b1;
                        timer_next = off_reg;
                    end
                end
            end
            S_EMIT: begin
                if (cnt_reg == '0) st_next = S_IDLE;
                else if (m_tready) begin
                    rd_next = rd_reg + 1'b1;
                    if (rd_next == cnt_reg) st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
        // the newest word is the last one so far
        if (res_we) res_w.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            listen_reg <= 16'd1; off_reg <= 16'd15; node_reg <= 16'd1;
            st_reg <= S_IDLE; phase_reg <= 1'b0; timer_reg <= '0; adj_reg <= '0;
            lleft_reg <= '0; duty_reg <= 1'b1; radio_reg <= 1'b0; valid_reg <= '0;
            sent_reg <= '0; cnt_reg <= '0; rd_reg <= '0; idx_reg <= '0;
            found_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LISTEN: listen_reg <= cfg_wdata;
                    CFG_OFF:    off_reg    <= cfg_wdata;
                    CFG_NODE:   node_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            st_reg <= st_next; phase_reg <= phase_next; timer_reg <= timer_next;
            adj_reg <= adj_next; lleft_reg <= lleft_next; duty_reg <= duty_next;
            radio_reg <= radio_next; valid_reg <= valid_next; sent_reg <= sent_next;
            cnt_reg <= cnt_next; rd_reg <= rd_next; idx_reg <= idx_next;
            found_reg <= found_next;
        end
    end

    // payload registers and result buffer, last marked on the newest word
    always_ff @(posedge aclk) begin
        if (st_reg == S_IDLE && s_tvalid) in_reg <= s_tdata;
        rem_reg <= rem_next; quo_src_reg <= quo_src_next; bit_reg <= bit_next;
        free_reg <= free_next;
        if (life_we) life_reg[wslot] <= life_w;
        if (dest_we) dest_reg[wslot] <= addr;
        if (res_we) begin
            res_reg[cnt_reg] <= res_w;
            if (cnt_reg != '0) res_reg[cnt_reg - 1'b1].last <= 1'b0;
        end
    end
endmodule

FILE: rtl/core/lppdc_checker.sv
// port-level checks for the duty cycler top level
// depends on the defines header and lppdc_pkg
`timescale 1ns / 1ps
`include "low_power_probing_duty_cycler_top_defines.svh"
module lppdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);
    import lppdc_pkg::*;
    // no new word taken while results are pending
    `LPP_ASSERT_NOW(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready, "input during output")
    // a taken word makes the block busy
    `LPP_ASSERT_NEXT(a_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready, "ready after accept")
    // kind is always a known code
    `LPP_ASSERT_NOW(a_kind, aclk, aresetn, m_tvalid, m_tdata[2:0] <= 3'd4, "bad kind")
    // a stalled result holds
    `LPP_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && m_tvalid, "stalled word changed")
    // nothing follows the last word of an item
    `LPP_ASSERT_NEXT(a_last, aclk, aresetn, m_tvalid && m_tready && m_tlast, !m_tvalid, "word after last")
endmodule

bind low_power_probing_duty_cycler_top lppdc_checker u_lppdc_checker (.*);

FILE: dv/tb_top.sv
// self-checking bench for the low-power probing duty cycler top level
// drives input words from a stimulus table then random runs, checks results against a predictor
// depends on lppdc_pkg and low_power_probing_duty_cycler_top
`timescale 1ns / 1ps
module tb_top;
    import lppdc_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;

    low_power_probing_duty_cycler_top u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    typedef struct packed {
        logic [15:0] rnd;
        logic        rcv;
        logic        busy;
        logic [7:0]  periods;
        logic        pwr;
        logic        flag;
        logic [1:0]  slot;
        logic [15:0] src;
        logic [15:0] addr;
        logic [2:0]  mode;
    } word_t;

    // expected result: 25 bits of tdata plus last
    typedef struct packed {
        logic        last;
        logic [24:0] data;
    } exp_t;

    // predictor copy of block state
    logic [15:0] p_listen, p_off, p_node;
    logic        p_phase;
    logic [15:0] p_timer, p_adjust;
    logic [7:0]  p_left;
    logic        p_duty, p_radio;
    logic [3:0]  p_valid;
    logic [15:0] p_dest [4];
    logic [16:0] p_life [4];
    logic [3:0]  p_sent;

    exp_t result_q[$];
    int   errors;
    int   cycles;
    int   limit;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // cycle counter and overall timeout
    initial begin
        cycles = 0;
        limit  = 3000000;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > limit) begin
                $display("[low_power_probing_duty_cycler_top] ERROR");
                $finish;
            end
        end
    end

    function automatic void push_res(kind_t k, logic [1:0] sl, logic [1:0] st,
                                     logic tx, logic [15:0] peer);
        exp_t e;
        e.last = 1'b0;
        e.data = {p_radio, peer, tx, st, sl, k};
        result_q.push_back(e);
    endfunction

    function automatic void predict_reset();
        p_listen = 16'd1; p_off = 16'd15; p_node = 16'd1;
        p_phase = 1'b0; p_timer = '0; p_adjust = '0; p_left = '0;
        p_duty = 1'b1; p_radio = 1'b0; p_valid = '0; p_sent = '0;
        for (int i = 0; i < 4; i++) begin
            p_dest[i] = '0;
            p_life[i] = '0;
        end
    endfunction

    function automatic void predict_cfg(logic [1:0] idx, logic [15:0] val);
        if (idx == CFG_LISTEN) p_listen = val;
        else if (idx == CFG_OFF) p_off = val;
        else if (idx == CFG_NODE) p_node = val;
    endfunction

    function automatic void maybe_off();
        if (p_duty) p_radio = 1'b0;
    endfunction

    // duty cycle step when the phase timer fires
    function automatic void predict_cycle(word_t w);
        logic [15:0] div;
        int cur, floor2;
        if (!p_phase) begin
            div = p_off >> 1;
            p_radio = 1'b1;
            if (w.busy) p_adjust = (div != 0) ? w.rnd % div : 16'd0;
            else push_res(KIND_PROBE, 2'd0, ST_OK, 1'b0, 16'd0);
            p_phase = 1'b1;
            p_timer = p_listen;
            return;
        end
        if (p_valid == 0 && p_left == 0) begin
            cur = int'(p_off) - int'(p_adjust);
            floor2 = int'(p_listen) * 2;
            if (!w.rcv) maybe_off();
            if (cur < floor2) cur = floor2;
            p_adjust = '0;
            p_timer = (cur > 65535) ? 16'hFFFF : cur[15:0];
        end else begin
            if (p_valid == 0) p_left--;
            p_timer = p_off;
        end
        p_phase = 1'b0;
    endfunction

    // expected results of one accepted input word
    function automatic void predict_word(word_t w);
        int n0, fs, n;
        logic [17:0] life;
        logic ok;
        n0 = result_q.size();
        case (w.mode)
            MODE_TICK: begin
                for (int i = 0; i < 4; i++) begin
                    if (!p_valid[i]) continue;
                    if (p_life[i] > 1) p_life[i]--;
                    else if (result_q.size() - n0 < MAX_RESULTS - 1) begin
                        p_valid[i] = 1'b0;
                        if (p_valid == 0 && p_left == 0) maybe_off();
                        push_res(KIND_COMPLETE, i[1:0], ST_NO_ACK, p_sent[i], 16'd0);
                    end
                end
                if (p_timer > 1) p_timer--;
                else begin
                    p_timer = '0;
                    predict_cycle(w);
                end
            end
            MODE_ENQUEUE: begin
                fs = -1;
                for (int i = 0; i < 4; i++)
                    if (!p_valid[i] && fs < 0) fs = i;
                if (fs < 0) push_res(KIND_COMPLETE, 2'd0, ST_NO_SLOT, 1'b0, 16'd0);
                else begin
                    life = p_listen + p_off;
                    if (w.addr != 0) life = life + (life >> 1);
                    if (life > 18'h1FFFF) life = 18'h1FFFF;
                    p_valid[fs] = 1'b1;
                    p_dest[fs] = w.addr;
                    p_life[fs] = life[16:0];
                    p_sent[fs] = 1'b0;
                    p_radio = 1'b1;
                    push_res(KIND_ACCEPTED, fs[1:0], ST_OK, 1'b0, 16'd0);
                end
            end
            MODE_PROBE: begin
                for (int i = 0; i < 4; i++) begin
                    if (!p_valid[i]) continue;
                    if (p_dest[i] != w.addr && p_dest[i] != 0) continue;
                    if (p_dest[i] != 0 && p_sent[i]) continue;
                    p_sent[i] = 1'b1;
                    push_res(KIND_TRANSMIT, i[1:0], ST_OK, 1'b0, 16'd0);
                end
            end
            MODE_DATA: begin
                maybe_off();
                if (w.addr == 0 || w.addr == p_node)
                    push_res(KIND_DELIVER, 2'd0, ST_OK, 1'b0, w.src);
            end
            MODE_REPORT: begin
                if (p_valid[w.slot]) begin
                    ok = p_sent[w.slot] && w.flag;
                    p_valid[w.slot] = 1'b0;
                    if (p_valid == 0 && p_left == 0) maybe_off();
                    push_res(KIND_COMPLETE, w.slot, ok ? ST_OK : ST_NO_ACK,
                             p_sent[w.slot], 16'd0);
                end
            end
            MODE_LISTEN: begin
                p_left = w.periods;
                p_radio = 1'b1;
            end
            MODE_POWER: begin
                if (w.pwr) begin
                    p_duty = 1'b1;
                    p_radio = 1'b1;
                end else begin
                    p_duty = 1'b0;
                    p_radio = w.flag;
                end
            end
            default: ;
        endcase
        n = result_q.size();
        if (n > n0) result_q[n-1].last = 1'b1;
    endfunction

    // result side: random stalls and comparison with the oldest expectation
    initial begin
        exp_t e;
        int gap;
        m_tready = 1'b0;
        errors = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if ($urandom_range(0, 4) == 0) gap = 0;
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (result_q.size() == 0) begin
                $display("%0t unexpected word: actual %h last %b", $time,
                         m_tdata[24:0], m_tlast);
                errors++;
            end else begin
                e = result_q.pop_front();
                if (m_tdata[24:0] !== e.data || m_tlast !== e.last) begin
                    $display("%0t mismatch: expected %h last %b, actual %h last %b",
                             $time, e.data, e.last, m_tdata[24:0], m_tlast);
                    errors++;
                end
                if (m_tdata[31:25] !== 7'd0) begin
                    $display("%0t fill bits: expected 0, actual %h", $time, m_tdata[31:25]);
                    errors++;
                end
            end
        end
    end

    task automatic send_word(word_t w);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, w};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_word(w);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        predict_cfg(idx, val);
    endtask

    function automatic word_t mk(logic [2:0] m, logic [15:0] a);
        word_t w;
        w = '0;
        w.mode = m;
        w.addr = a;
        return w;
    endfunction

    function automatic word_t rand_word(logic [15:0] peer);
        word_t w;
        logic [95:0] r;
        r = {$urandom, $urandom, $urandom};
        w = r[64:0];
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8: w.mode = MODE_TICK;
            9, 10, 11: w.mode = MODE_ENQUEUE;
            12, 13: w.mode = MODE_PROBE;
            14: w.mode = MODE_DATA;
            15, 16: w.mode = MODE_REPORT;
            17: w.mode = MODE_LISTEN;
            18: w.mode = MODE_POWER;
            default: w.mode = 3'($urandom_range(0, 7));
        endcase
        // mostly a small peer set so probes and deliveries match
        if ($urandom_range(0, 3) != 0)
            w.addr = ($urandom_range(0, 2) == 0) ? 16'd0 : peer;
        if (w.mode == MODE_TICK) begin
            w.busy = ($urandom_range(0, 3) == 0);
            w.rcv  = ($urandom_range(0, 5) == 0);
        end
        if (w.mode == MODE_LISTEN) w.periods = $urandom_range(0, 3) == 0 ? w.periods : 8'd1;
        if (w.mode == MODE_POWER && $urandom_range(0, 2) != 0) w.pwr = 1'b1;
        return w;
    endfunction

    // directed table: words, with typed expectation where obvious
    word_t dir_tab [20];
    logic  dir_chk [20];
    logic [25:0] dir_exp [20];

    initial begin
        word_t w;
        logic [15:0] peer;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        predict_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < 20; i++) begin
            dir_chk[i] = 1'b0;
            dir_exp[i] = '0;
        end
        // first tick after reset probes with the radio on
        dir_tab[0] = mk(MODE_TICK, 16'd0);
        dir_chk[0] = 1'b1;
        dir_exp[0] = {1'b1, 1'b1, 16'd0, 1'b0, ST_OK, 2'd0, KIND_PROBE};
        dir_tab[1] = mk(MODE_ENQUEUE, 16'hFFFF);
        dir_tab[2] = mk(MODE_ENQUEUE, 16'd0);
        dir_tab[3] = mk(MODE_ENQUEUE, 16'd7);
        dir_tab[4] = mk(MODE_ENQUEUE, 16'd7);
        // table full: no free slot
        dir_tab[5] = mk(MODE_ENQUEUE, 16'd9);
        dir_chk[5] = 1'b1;
        dir_exp[5] = {1'b1, 1'b1, 16'd0, 1'b0, ST_NO_SLOT, 2'd0, KIND_COMPLETE};
        dir_tab[6] = mk(MODE_PROBE, 16'd7);
        dir_tab[7] = mk(MODE_PROBE, 16'd7);
        dir_tab[8] = mk(MODE_PROBE, 16'hFFFF);
        dir_tab[9] = mk(MODE_REPORT, 16'd0);
        dir_tab[9].slot = 2'd2; dir_tab[9].flag = 1'b1;
        dir_tab[10] = mk(MODE_REPORT, 16'd0);
        dir_tab[10].slot = 2'd3;
        dir_tab[11] = mk(MODE_REPORT, 16'd0);
        dir_tab[11].slot = 2'd3;
        dir_tab[12] = mk(MODE_DATA, 16'd1);
        dir_tab[12].src = 16'hFFFF;
        dir_tab[13] = mk(MODE_DATA, 16'd5);
        dir_tab[14] = mk(MODE_LISTEN, 16'd0);
        dir_tab[14].periods = 8'hFF;
        dir_tab[15] = mk(MODE_POWER, 16'd0);
        dir_tab[15].flag = 1'b1;
        dir_tab[16] = mk(MODE_POWER, 16'd0);
        dir_tab[17] = mk(MODE_POWER, 16'd0);
        dir_tab[17].pwr = 1'b1;
        dir_tab[18] = mk(3'd7, 16'hFFFF);
        dir_tab[19] = mk(MODE_TICK, 16'd0);
        dir_tab[19].busy = 1'b1; dir_tab[19].rnd = 16'hFFFF;

        for (int i = 0; i < 20; i++) begin
            send_word(dir_tab[i]);
            // the typed value must agree with the predictor
            if (dir_chk[i] && (result_q.size() == 0 || result_q[$] !== dir_exp[i])) begin
                $display("%0t table row %0d: expected %h, predicted differs", $time,
                         i, dir_exp[i]);
                errors++;
            end
        end

        // random phases across register settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_LISTEN, 16'd1); write_reg(CFG_OFF, 16'd2); end
                1: begin write_reg(CFG_LISTEN, 16'd2); write_reg(CFG_OFF, 16'd3); end
                2: begin write_reg(CFG_LISTEN, 16'd3); write_reg(CFG_OFF, 16'd20); end
                3: begin write_reg(CFG_LISTEN, 16'hFFFF); write_reg(CFG_OFF, 16'hFFFF); end
                4: begin write_reg(CFG_LISTEN, 16'd1); write_reg(CFG_OFF, 16'd9); end
                default: begin
                    write_reg(CFG_LISTEN, 16'($urandom_range(1, 4)));
                    write_reg(CFG_OFF, 16'($urandom_range(2, 40)));
                end
            endcase
            peer = (ph == 3) ? 16'hFFFF : (ph == 4 ? 16'd0 : 16'($urandom));
            write_reg(CFG_NODE, peer);
            for (int k = 0; k < 68; k++) begin
                w = rand_word(peer);
                send_word(w);
            end
        end
        s_tvalid <= 1'b0;

        while (result_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0)
            $display("[low_power_probing_duty_cycler_top] OK");
        else
            $display("[low_power_probing_duty_cycler_top] ERROR");
        $finish;
    end
endmodule
